@@ hw/rtl/ebcalu_pkg.sv @@
// Shared types and constants of the 8-bit CPU ALU with flags.
package ebcalu_pkg;

  typedef enum logic [3:0] {
    OP_RL    = 4'd0,
    OP_RLC   = 4'd1,
    OP_RR    = 4'd2,
    OP_RRC   = 4'd3,
    OP_ADD8  = 4'd4,
    OP_ADD16 = 4'd5,
    OP_SUB8  = 4'd6,
    OP_INC8  = 4'd7,
    OP_DEC8  = 4'd8,
    OP_CP    = 4'd9,
    OP_BIT   = 4'd10
  } alu_op_t;

  // Bit positions inside the flags byte
  localparam int unsigned FLAG_Z = 7;
  localparam int unsigned FLAG_N = 6;
  localparam int unsigned FLAG_H = 5;
  localparam int unsigned FLAG_C = 4;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned IN_TUSER_W  = 5;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef struct packed {
    logic        keep_zero_clear;
    logic [7:0]  flags_in;
    logic [15:0] operand_b;
    logic [15:0] operand_a;
    logic [3:0]  cmd;
  } alu_in_t;

  typedef struct packed {
    logic [7:0]  flags_out;
    logic [15:0] result_value;
  } alu_out_t;

endpackage

@@ hw/rtl/ebcalu_core.sv @@
// Combinational ALU: result value and flags byte for one word.
module ebcalu_core (
  input  ebcalu_pkg::alu_in_t  item_i,
  output ebcalu_pkg::alu_out_t res_o
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        cin;
  logic [8:0]  sum9;
  logic [8:0]  dif9;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [7:0]  rl8;
  logic [7:0]  rlc8;
  logic [7:0]  rr8;
  logic [7:0]  rrc8;
  logic        tbit;
  logic [15:0] val;
  logic        fz;
  logic        fn;
  logic        fh;
  logic        fc;

  assign a8    = item_i.operand_a[7:0];
  assign b8    = item_i.operand_b[7:0];
  assign cin   = item_i.flags_in[ebcalu_pkg::FLAG_C];
  assign sum9  = {1'b0, a8} + {1'b0, b8};
  assign dif9  = {1'b0, a8} - {1'b0, b8};
  assign inc8  = a8 + 8'd1;
  assign dec8  = a8 - 8'd1;
  assign sum17 = {1'b0, item_i.operand_a} + {1'b0, item_i.operand_b};
  assign sum13 = {1'b0, item_i.operand_a[11:0]} + {1'b0, item_i.operand_b[11:0]};
  assign rl8   = {a8[6:0], cin};
  assign rlc8  = {a8[6:0], a8[7]};
  assign rr8   = {cin, a8[7:1]};
  assign rrc8  = {a8[0], a8[7:1]};
  assign tbit  = a8[b8[2:0]];

  always_comb begin
    val = item_i.operand_a;
    fz  = item_i.flags_in[ebcalu_pkg::FLAG_Z];
    fn  = item_i.flags_in[ebcalu_pkg::FLAG_N];
    fh  = item_i.flags_in[ebcalu_pkg::FLAG_H];
    fc  = cin;
    unique case (item_i.cmd)
      ebcalu_pkg::OP_RL: begin
        val = {8'h00, rl8};
        fz  = (rl8 == 8'h00);
        fn  = 1'b0;
        fh  = 1'b0;
        fc  = a8[7];
      end
      ebcalu_pkg::OP_RLC: begin
        val = {8'h00, rlc8};
        fz  = !item_i.keep_zero_clear && (rlc8 == 8'h00);
        fn  = 1'b0;
        fh  = 1'b0;
        fc  = a8[7];
      end
      ebcalu_pkg::OP_RR: begin
        val = {8'h00, rr8};
        fz  = (rr8 == 8'h00);
        fn  = 1'b0;
        fh  = 1'b0;
        fc  = a8[0];
      end
      ebcalu_pkg::OP_RRC: begin
        val = {8'h00, rrc8};
        fz  = (rrc8 == 8'h00);
        fn  = 1'b0;
        fh  = 1'b0;
        fc  = a8[0];
      end
      ebcalu_pkg::OP_ADD8: begin
        val = {8'h00, sum9[7:0]};
        fz  = (sum9[7:0] == 8'h00);
        fn  = 1'b0;
        fh  = a8[4] ^ b8[4] ^ sum9[4];
        fc  = sum9[8];
      end
      ebcalu_pkg::OP_ADD16: begin
        val = sum17[15:0];
        fz  = (sum17[15:0] == 16'h0000);
        fn  = 1'b0;
        fh  = sum13[12];
        fc  = sum17[16];
      end
      ebcalu_pkg::OP_SUB8: begin
        val = {8'h00, dif9[7:0]};
        fz  = (dif9[7:0] == 8'h00);
        fn  = 1'b1;
        fh  = (b8[3:0] > a8[3:0]);
        fc  = dif9[8];
      end
      ebcalu_pkg::OP_INC8: begin
        val = {8'h00, inc8};
        fz  = (inc8 == 8'h00);
        fn  = 1'b0;
        fh  = (a8[3:0] == 4'hF);
      end
      ebcalu_pkg::OP_DEC8: begin
        val = {8'h00, dec8};
        fz  = (dec8 == 8'h00);
        fn  = 1'b1;
        fh  = (a8[3:0] == 4'h0);
      end
      ebcalu_pkg::OP_CP: begin
        fz = (dif9[7:0] == 8'h00);
        fn = 1'b1;
        fh = (b8[3:0] > a8[3:0]);
        fc = dif9[8];
      end
      ebcalu_pkg::OP_BIT: begin
        fz = !tbit;
        fn = 1'b0;
        fh = 1'b1;
      end
      default: begin
        // unused codes pass value and upper flags through
      end
    endcase
  end

  assign res_o.result_value = val;
  assign res_o.flags_out    = {fz, fn, fh, fc, 4'h0};

endmodule

@@ hw/rtl/eight_bit_cpu_alu_with_flags.sv @@
// Top level: input register, flag ALU and result register on stream channels.
//
//  channel | direction | ports                    | tdata / tuser
//  --------+-----------+--------------------------+------------------------------------
//  in      | slave     | in_tvalid/tready/tdata/  | tdata: operand_a, operand_b, flags_in
//          |           | tuser                    | tuser: cmd, keep_zero_clear
//  out     | master    | out_tvalid/tready/tdata  | tdata: result_value, flags_out
//
// One word per clock sustained while out_tready stays high; an accepted word passes
// through the input register, then the ALU and the result register, to out_tvalid.
// rst_n (synchronous, active low) empties both registers.
// A stalled out_tready holds the result word; the input register still fills,
// so in_tready drops only when both registers are full and out is stalled.
module eight_bit_cpu_alu_with_flags (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [15:0] operand_a, [31:16] operand_b, [39:32] flags_in
  input  logic [ebcalu_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [3:0] cmd, [4] keep_zero_clear
  input  logic [ebcalu_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [15:0] result_value, [23:16] flags_out
  output logic [ebcalu_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic                 s1_v_r;
  logic                 s1_v_nxt;
  ebcalu_pkg::alu_in_t  s1_item_r;
  ebcalu_pkg::alu_in_t  in_item;
  logic                 out_v_r;
  logic                 out_v_nxt;
  ebcalu_pkg::alu_out_t out_res_r;
  ebcalu_pkg::alu_out_t alu_res;
  logic                 in_acc;
  logic                 s1_adv;

  assign in_item.cmd             = in_tuser[3:0];
  assign in_item.keep_zero_clear = in_tuser[4];
  assign in_item.operand_a       = in_tdata[15:0];
  assign in_item.operand_b       = in_tdata[31:16];
  assign in_item.flags_in        = in_tdata[39:32];

  // advance into the result register when it is empty or being drained
  assign s1_adv    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_tready) begin
      s1_v_nxt = in_tvalid;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv && s1_v_r) begin
      out_res_r <= alu_res;
    end
  end

  ebcalu_core u_core (
    .item_i (s1_item_r),
    .res_o  (alu_res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_res_r;

  a_flags_low_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:16] == 4'h0))
    else $error("flags low nibble not clear");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted word lost before input register");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_adv) |=> out_v_r)
    else $error("advancing word did not reach result register");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_item_r)))
    else $error("input register changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_tready)
    else $error("input not ready with empty input register");

endmodule
